FILE: design/periodic_timer_table_core_assert.svh
// Assertion macros for the periodic timer table core.
// Included by ptt_dp, the RTL module that carries concurrent checks; no other dependencies.
`ifndef PERIODIC_TIMER_TABLE_CORE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// ante holds in a cycle -> cons holds in the same cycle
`define PTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante holds in a cycle -> cons holds in the next cycle
`define PTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PTT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PTT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: design/ptt_pkg.sv
// Shared constants, codes and control/status types of the periodic timer table.
// No dependencies; used by every RTL module of the block.
`timescale 1ns / 1ps

package ptt_pkg;

    localparam int MAX_TIMERS = 8;
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

    localparam int ID_W       = 32;
    localparam int PER_W      = 32;
    localparam int TIME_W     = 64;
    localparam int BASE_W     = 16;
    localparam int LIM_W      = 4;
    localparam int REPORT_MAX = 8;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_STEPS  = TIME_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TICK    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_LIMIT = 1'd1;

    localparam logic [BASE_W-1:0] BASE_TICK_RST    = 16'd1;
    localparam logic [LIM_W-1:0]  REPORT_LIMIT_RST = 4'd8;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_ADD  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ADD  = 2'd0,
        KIND_FIRE = 2'd1,
        KIND_NONE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_PERIOD = 2'd1,
        ST_FULL       = 2'd2,
        ST_DUP        = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_ADD,
        EMIT_FIRE,
        EMIT_END
    } emit_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_CHK,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_OUT,
        S_T_RD,
        S_T_SCAN,
        S_T_DUE,
        S_T_DIV,
        S_T_UPD,
        S_T_RPT,
        S_T_END
    } state_t;

    typedef struct packed {
        logic    load_in;
        logic    adv_elapsed;
        logic    clr_scan;
        logic    idx_inc;
        logic    cap_diff;
        logic    rem_short;
        logic    div_start;
        logic    wr_due;
        logic    wr_entry;
        logic    take_id;
        logic    set_status;
        status_t status;
        emit_t   emit;
    } dp_cmd_t;

    typedef struct packed {
        logic period_zero;
        logic table_full;
        logic idx_at_count;
        logic id_match;
        logic is_due;
        logic d_small;
        logic div_done;
        logic n_at_limit;
        logic held_valid;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: design/ptt_rem.sv
// Iterative 64-by-32 remainder unit, one quotient bit per cycle.
// Depends on ptt_pkg for widths and step count.
`timescale 1ns / 1ps

module ptt_rem (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [ptt_pkg::TIME_W-1:0] dividend,
    input  logic [ptt_pkg::PER_W-1:0]  divisor,
    output logic                      busy,
    output logic                      done,
    output logic [ptt_pkg::PER_W-1:0]  rem
);

    logic [ptt_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [ptt_pkg::TIME_W-1:0]    dvd_reg;
    logic [ptt_pkg::PER_W-1:0]     dvs_reg;
    logic [ptt_pkg::PER_W-1:0]     rem_reg;

    logic [ptt_pkg::PER_W:0]       shifted;
    logic [ptt_pkg::PER_W+1:0]     trial;
    logic [ptt_pkg::PER_W-1:0]     rem_next;

    assign shifted  = {rem_reg, dvd_reg[ptt_pkg::TIME_W-1]};
    assign trial    = {1'b0, shifted} - {2'b00, dvs_reg};
    // borrow set: partial remainder below divisor, keep it
    assign rem_next = trial[ptt_pkg::PER_W+1] ? shifted[ptt_pkg::PER_W-1:0]
                                               : trial[ptt_pkg::PER_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == ptt_pkg::DIV_CNT_W'(1));
            if (start)
            begin
                cnt_reg <= ptt_pkg::DIV_CNT_W'(ptt_pkg::DIV_STEPS);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - ptt_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[ptt_pkg::TIME_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

FILE: design/ptt_dp.sv
// Datapath: timer table, elapsed time, scan counters, remainder unit, output register.
// Depends on ptt_pkg, ptt_rem and periodic_timer_table_core_assert.svh.
`timescale 1ns / 1ps
`include "periodic_timer_table_core_assert.svh"

module ptt_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptt_pkg::dp_cmd_t            cmd,
    output ptt_pkg::dp_stat_t           stat,
    input  logic [ptt_pkg::ID_W-1:0]    timer_id,
    input  logic [ptt_pkg::PER_W-1:0]   period,
    input  logic [ptt_pkg::BASE_W-1:0]  base_tick,
    input  logic [ptt_pkg::LIM_W-1:0]   limit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  kind,
    output logic [1:0]                  status,
    output logic [ptt_pkg::ID_W-1:0]    fired_id,
    output logic                        last
);

    // captured input transaction
    logic [ptt_pkg::ID_W-1:0]   id_in_reg;
    logic [ptt_pkg::PER_W-1:0]  per_in_reg;

    logic [ptt_pkg::TIME_W-1:0] elapsed_reg;
    logic [ptt_pkg::CNT_W-1:0]  count_reg;
    logic [ptt_pkg::CNT_W-1:0]  idx_reg;
    logic [ptt_pkg::LIM_W-1:0]  n_reg;
    logic                       held_valid_reg;
    logic [ptt_pkg::ID_W-1:0]   held_id_reg;
    ptt_pkg::status_t           status_reg;
    logic [ptt_pkg::TIME_W-1:0] d_reg;
    logic [ptt_pkg::PER_W-1:0]  rem_reg;

    // table storage, registered read at the scan index
    logic [ptt_pkg::ID_W-1:0]   id_mem  [ptt_pkg::MAX_TIMERS];
    logic [ptt_pkg::PER_W-1:0]  per_mem [ptt_pkg::MAX_TIMERS];
    logic [ptt_pkg::TIME_W-1:0] due_mem [ptt_pkg::MAX_TIMERS];
    logic [ptt_pkg::ID_W-1:0]   rd_id_reg;
    logic [ptt_pkg::PER_W-1:0]  rd_per_reg;
    logic [ptt_pkg::TIME_W-1:0] rd_due_reg;

    logic                       out_valid_reg;
    ptt_pkg::kind_t             out_kind_reg;
    ptt_pkg::status_t           out_status_reg;
    logic [ptt_pkg::ID_W-1:0]   out_id_reg;
    logic                       out_last_reg;

    logic [ptt_pkg::IDX_W-1:0]  rd_idx;
    logic [ptt_pkg::IDX_W-1:0]  wr_idx;
    logic [ptt_pkg::TIME_W:0]   diff;
    logic [ptt_pkg::PER_W-1:0]  step;
    logic [ptt_pkg::TIME_W-1:0] new_due;
    logic [ptt_pkg::TIME_W-1:0] add_due;
    logic                       out_free;
    logic                       div_busy;
    logic                       div_done;
    logic [ptt_pkg::PER_W-1:0]  div_rem;

    assign rd_idx  = idx_reg[ptt_pkg::IDX_W-1:0];
    assign wr_idx  = cmd.wr_entry ? count_reg[ptt_pkg::IDX_W-1:0] : idx_reg[ptt_pkg::IDX_W-1:0];

    // borrow of elapsed - due doubles as the due test
    assign diff    = {1'b0, elapsed_reg} - {1'b0, rd_due_reg};
    // rem < period, so period - rem never wraps
    assign step    = rd_per_reg - rem_reg;
    assign new_due = elapsed_reg + {{(ptt_pkg::TIME_W - ptt_pkg::PER_W){1'b0}}, step};
    assign add_due = elapsed_reg + {{(ptt_pkg::TIME_W - ptt_pkg::PER_W){1'b0}}, per_in_reg};

    assign out_free = !out_valid_reg || out_ready;

    ptt_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (d_reg),
        .divisor  (rd_per_reg),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg    <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            n_reg          <= '0;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.adv_elapsed)
            begin
                elapsed_reg <= elapsed_reg
                             + {{(ptt_pkg::TIME_W - ptt_pkg::BASE_W){1'b0}}, base_tick};
            end
            if (cmd.wr_entry)
            begin
                count_reg <= count_reg + ptt_pkg::CNT_W'(1);
            end
            if (cmd.clr_scan)
            begin
                idx_reg        <= '0;
                n_reg          <= '0;
                held_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + ptt_pkg::CNT_W'(1);
                end
                if (cmd.take_id)
                begin
                    n_reg          <= n_reg + ptt_pkg::LIM_W'(1);
                    held_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            id_in_reg  <= timer_id;
            per_in_reg <= period;
        end
        if (cmd.take_id)
        begin
            held_id_reg <= rd_id_reg;
        end
        if (cmd.set_status)
        begin
            status_reg <= cmd.status;
        end
        if (cmd.cap_diff)
        begin
            d_reg <= diff[ptt_pkg::TIME_W-1:0];
        end
        if (cmd.rem_short)
        begin
            rem_reg <= d_reg[ptt_pkg::PER_W-1:0];
        end
        else if (div_done)
        begin
            rem_reg <= div_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_entry)
        begin
            id_mem[wr_idx]  <= id_in_reg;
            per_mem[wr_idx] <= per_in_reg;
        end
        if (cmd.wr_entry || cmd.wr_due)
        begin
            due_mem[wr_idx] <= cmd.wr_entry ? add_due : new_due;
        end
        rd_id_reg  <= id_mem[rd_idx];
        rd_per_reg <= per_mem[rd_idx];
        rd_due_reg <= due_mem[rd_idx];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != ptt_pkg::EMIT_IDLE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.emit)
            ptt_pkg::EMIT_ADD:
            begin
                out_kind_reg   <= ptt_pkg::KIND_ADD;
                out_status_reg <= status_reg;
                out_id_reg     <= '0;
                out_last_reg   <= 1'b1;
            end
            ptt_pkg::EMIT_FIRE:
            begin
                out_kind_reg   <= ptt_pkg::KIND_FIRE;
                out_status_reg <= ptt_pkg::ST_OK;
                out_id_reg     <= held_id_reg;
                out_last_reg   <= 1'b0;
            end
            ptt_pkg::EMIT_END:
            begin
                out_kind_reg   <= held_valid_reg ? ptt_pkg::KIND_FIRE : ptt_pkg::KIND_NONE;
                out_status_reg <= ptt_pkg::ST_OK;
                out_id_reg     <= held_valid_reg ? held_id_reg : '0;
                out_last_reg   <= 1'b1;
            end
            default:
            begin
                out_kind_reg   <= out_kind_reg;
                out_status_reg <= out_status_reg;
                out_id_reg     <= out_id_reg;
                out_last_reg   <= out_last_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_kind_reg;
    assign status    = out_status_reg;
    assign fired_id  = out_id_reg;
    assign last      = out_last_reg;

    assign stat.period_zero  = (per_in_reg == '0);
    assign stat.table_full   = (count_reg == ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS));
    assign stat.idx_at_count = (idx_reg == count_reg);
    assign stat.id_match     = (rd_id_reg == id_in_reg);
    assign stat.is_due       = !diff[ptt_pkg::TIME_W];
    assign stat.d_small      = (d_reg[ptt_pkg::TIME_W-1:ptt_pkg::PER_W] == '0)
                            && (d_reg[ptt_pkg::PER_W-1:0] < rd_per_reg);
    assign stat.div_done     = div_done;
    assign stat.n_at_limit   = (n_reg >= limit);
    assign stat.held_valid   = held_valid_reg;
    assign stat.out_free     = out_free;

    `PTT_ASSERT_IMP(a_no_write_full, clk, rst_n, cmd.wr_entry, count_reg < ptt_pkg::CNT_W'(ptt_pkg::MAX_TIMERS), "entry written into a full table")
    `PTT_ASSERT_NXT(a_count_step, clk, rst_n, cmd.wr_entry, count_reg == ptt_pkg::CNT_W'($past(count_reg) + 1'b1), "entry count did not advance by one")
    `PTT_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit != ptt_pkg::EMIT_IDLE, out_free, "result loaded over a pending result")
    `PTT_ASSERT_IMP(a_div_idle, clk, rst_n, cmd.div_start, !div_busy, "remainder unit restarted while busy")
    `PTT_ASSERT_IMP(a_report_limit, clk, rst_n, cmd.take_id, n_reg < limit, "fired id reported past the limit")

endmodule

FILE: design/ptt_ctrl.sv
// Controller state machine: sequences add checks and tick scans over the table.
// Depends on ptt_pkg for state, command and status types.
`timescale 1ns / 1ps

module ptt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              command,
    output logic              in_ready,
    input  ptt_pkg::dp_stat_t stat,
    output ptt_pkg::dp_cmd_t  cmd
);

    ptt_pkg::state_t state_reg;
    ptt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ptt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in  = 1'b1;
                    cmd.clr_scan = 1'b1;
                    if (command == ptt_pkg::CMD_ADD)
                    begin
                        state_next = ptt_pkg::S_ADD_CHK;
                    end
                    else
                    begin
                        cmd.adv_elapsed = 1'b1;
                        state_next      = ptt_pkg::S_T_RD;
                    end
                end
            end
            ptt_pkg::S_ADD_CHK:
            begin
                if (stat.period_zero)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ptt_pkg::ST_BAD_PERIOD;
                    state_next     = ptt_pkg::S_ADD_OUT;
                end
                else if (stat.table_full)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ptt_pkg::ST_FULL;
                    state_next     = ptt_pkg::S_ADD_OUT;
                end
                else
                begin
                    // entry 0 is read during this cycle
                    state_next = ptt_pkg::S_ADD_CMP;
                end
            end
            ptt_pkg::S_ADD_RD:
            begin
                state_next = ptt_pkg::S_ADD_CMP;
            end
            ptt_pkg::S_ADD_CMP:
            begin
                if (stat.idx_at_count)
                begin
                    cmd.wr_entry   = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = ptt_pkg::ST_OK;
                    state_next     = ptt_pkg::S_ADD_OUT;
                end
                else if (stat.id_match)
                begin
                    cmd.set_status = 1'b1;
                    cmd.status     = ptt_pkg::ST_DUP;
                    state_next     = ptt_pkg::S_ADD_OUT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ptt_pkg::S_ADD_RD;
                end
            end
            ptt_pkg::S_ADD_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = ptt_pkg::EMIT_ADD;
                    state_next = ptt_pkg::S_IDLE;
                end
            end
            ptt_pkg::S_T_RD:
            begin
                state_next = ptt_pkg::S_T_SCAN;
            end
            ptt_pkg::S_T_SCAN:
            begin
                if (stat.idx_at_count)
                begin
                    state_next = ptt_pkg::S_T_END;
                end
                else if (stat.is_due)
                begin
                    cmd.cap_diff = 1'b1;
                    state_next   = ptt_pkg::S_T_DUE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ptt_pkg::S_T_RD;
                end
            end
            ptt_pkg::S_T_DUE:
            begin
                // lag under one period: remainder is the lag itself
                if (stat.d_small)
                begin
                    cmd.rem_short = 1'b1;
                    state_next    = ptt_pkg::S_T_UPD;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ptt_pkg::S_T_DIV;
                end
            end
            ptt_pkg::S_T_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = ptt_pkg::S_T_UPD;
                end
            end
            ptt_pkg::S_T_UPD:
            begin
                cmd.wr_due = 1'b1;
                state_next = ptt_pkg::S_T_RPT;
            end
            ptt_pkg::S_T_RPT:
            begin
                // one id is held back so the final one can carry last
                if (stat.n_at_limit)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ptt_pkg::S_T_RD;
                end
                else if (!stat.held_valid)
                begin
                    cmd.take_id = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = ptt_pkg::S_T_RD;
                end
                else if (stat.out_free)
                begin
                    cmd.emit    = ptt_pkg::EMIT_FIRE;
                    cmd.take_id = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = ptt_pkg::S_T_RD;
                end
            end
            ptt_pkg::S_T_END:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = ptt_pkg::EMIT_END;
                    state_next = ptt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ptt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/periodic_timer_table_core.sv
// Top level of the periodic timer table: configuration registers, controller, datapath.
// Depends on ptt_pkg, ptt_ctrl, ptt_dp (and through it ptt_rem).
`timescale 1ns / 1ps

// Channel   Signals                                   Direction  Transaction
// --------  ----------------------------------------  ---------  ---------------------------
// in        in_valid/in_ready command timer_id period  input      one add or tick command
// out       out_valid/out_ready kind status fired_id   output     one result, last on final
//           last
// cfg       cfg_we cfg_addr cfg_wdata                  input      write when cfg_we is high
//
// Add: linear duplicate-id scan over the table through the registered table read.
// Tick: a scan over every entry; a due entry lagging by a period or more goes through the
//   bit-serial remainder unit.
// Reset clears elapsed time, entry count, controller and output valid; table contents are
//   written before they are read, so they need no clearing.
// A new command is taken only when the controller is idle; a result waiting in the output
//   register does not hold off the next command, and a stalled output pauses the scan.

module periodic_timer_table_core (
    input  logic                            clk,
    input  logic                            rst_n,
    // command channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [ptt_pkg::ID_W-1:0]        timer_id,
    input  logic [ptt_pkg::PER_W-1:0]       period,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      kind,
    output logic [1:0]                      status,
    output logic [ptt_pkg::ID_W-1:0]        fired_id,
    output logic                            last,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ptt_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ptt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    logic [ptt_pkg::BASE_W-1:0] base_tick_reg;
    logic [ptt_pkg::LIM_W-1:0]  report_limit_reg;
    logic [ptt_pkg::LIM_W-1:0]  limit_eff;

    ptt_pkg::dp_cmd_t  dp_cmd;
    ptt_pkg::dp_stat_t dp_stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_tick_reg    <= ptt_pkg::BASE_TICK_RST;
            report_limit_reg <= ptt_pkg::REPORT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ptt_pkg::CFG_BASE_TICK:
                begin
                    base_tick_reg <= cfg_wdata[ptt_pkg::BASE_W-1:0];
                end
                ptt_pkg::CFG_REPORT_LIMIT:
                begin
                    report_limit_reg <= cfg_wdata[ptt_pkg::LIM_W-1:0];
                end
                default:
                begin
                    base_tick_reg <= base_tick_reg;
                end
            endcase
        end
    end

    // zero behaves as one, anything above the report maximum as the maximum
    always_comb
    begin
        if (report_limit_reg == '0)
        begin
            limit_eff = ptt_pkg::LIM_W'(1);
        end
        else if (report_limit_reg > ptt_pkg::LIM_W'(ptt_pkg::REPORT_MAX))
        begin
            limit_eff = ptt_pkg::LIM_W'(ptt_pkg::REPORT_MAX);
        end
        else
        begin
            limit_eff = report_limit_reg;
        end
    end

    ptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    ptt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .timer_id  (timer_id),
        .period    (period),
        .base_tick (base_tick_reg),
        .limit     (limit_eff),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .status    (status),
        .fired_id  (fired_id),
        .last      (last)
    );

endmodule
